// File: rtl/tvc_pkg.sv
// Package for the two-voice chorus: sizes, register indexes and the
// quarter-wave sine table built at elaboration. No dependencies.
package tvc_pkg;

    localparam int DELAY_DEPTH      = 8192;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SAMPLE_BITS      = 16;

    localparam int FRAC_BITS = 8;
    localparam int DLY_AW    = $clog2(DELAY_DEPTH);
    localparam int POS_W     = DLY_AW + FRAC_BITS;
    localparam int SIN_AW    = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_QTR  = SINE_TABLE_DEPTH / 4;
    localparam int QTR_AW    = SIN_AW - 2;

    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] R_STEP      = ONE_Q30 / SINE_QTR;

    typedef enum logic [2:0] {
        CFG_G1    = 3'd0,
        CFG_G2    = 3'd1,
        CFG_D1    = 3'd2,
        CFG_D2    = 3'd3,
        CFG_STEP1 = 3'd4,
        CFG_STEP2 = 3'd5
    } t_cfg_idx;

    typedef logic [14:0] t_sine_rom [SINE_QTR];

    // first-quadrant magnitude, Q15, for quarter index 0..SINE_QTR
    function automatic logic [14:0] f_quarter(input int unsigned i);
        logic [63:0] r, x, x2, p, s, q;
        begin
            r  = 64'(i) * R_STEP;
            x  = (r * HALF_PI_Q30) >> 30;
            x2 = (x * x) >> 30;
            p  = ONE_Q30;
            p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd110;
            p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd72;
            p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd42;
            p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd20;
            p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd6;
            s  = (x * p) >> 30;
            q  = (s + 64'd16384) >> 15;
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            f_quarter = q[14:0];
        end
    endfunction

    function automatic t_sine_rom f_build_rom();
        t_sine_rom t;
        begin
            for (int k = 0; k < SINE_QTR; k++) begin
                t[k] = f_quarter(k);
            end
            f_build_rom = t;
        end
    endfunction

    localparam t_sine_rom   SINE_ROM  = f_build_rom();
    localparam logic [14:0] SINE_PEAK = f_quarter(SINE_QTR);

endpackage

// File: rtl/tvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tvc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/two_voice_chorus.sv
// Two-voice chorus top level: delay memory, LFO phases, voice interpolation, mix.
// Depends on tvc_pkg and tvc_ram.
//
// One sample in, one sample out. After reset the delay memory is zeroed by a
// clearing pass over all DELAY_DEPTH (8192) addresses during which no sample is
// taken; config writes are taken at any time. Each sample then takes one
// memory write plus four reads through the single read port of the delay RAM,
// then interpolation, three gain products and the rounded, saturated sum. The
// next sample is taken while the previous result waits at the output.
module two_voice_chorus (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [tvc_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [tvc_pkg::SAMPLE_BITS-1:0] o_sample_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [2:0]                          i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);
    localparam int SB = tvc_pkg::SAMPLE_BITS;
    localparam int AW = tvc_pkg::DLY_AW;
    localparam int PW = tvc_pkg::POS_W;
    localparam int FB = tvc_pkg::FRAC_BITS;
    localparam int WW = SB + FB + 2;
    localparam int AccW = WW + 17 + 2;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_WRITE = 7'b0000100,
        S_READ  = 7'b0001000,
        S_VOICE = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_SUM   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_g1, r_g2;
    logic [11:0] r_d1, r_d2;
    logic [31:0] r_step1, r_step2, r_ph1, r_ph2;
    logic [AW-1:0] r_rp, r_clr;
    logic signed [SB-1:0] r_dry;
    logic signed [15:0] r_sin1, r_sin2;
    logic [PW-1:0] r_pos1, r_pos2;
    logic [2:0] r_rd;
    logic signed [SB-1:0] r_x [4];
    logic signed [WW-1:0] r_w1, r_w2;
    logic signed [AccW-1:0] r_p0, r_p1, r_p2;
    logic r_ovalid;
    logic signed [SB-1:0] r_y;

    // sine lookup
    function automatic logic signed [15:0] f_sine(input logic [31:0] ph);
        logic [tvc_pkg::SIN_AW-1:0] ti;
        logic [tvc_pkg::QTR_AW:0] ridx;
        logic [14:0] mag;
        begin
            ti = ph[31 -: tvc_pkg::SIN_AW];
            if (ti[tvc_pkg::SIN_AW-2]) begin
                ridx = (tvc_pkg::QTR_AW+1)'(tvc_pkg::SINE_QTR)
                     - {1'b0, ti[tvc_pkg::QTR_AW-1:0]};
            end else begin
                ridx = {1'b0, ti[tvc_pkg::QTR_AW-1:0]};
            end
            mag = ridx[tvc_pkg::QTR_AW] ? tvc_pkg::SINE_PEAK
                                        : tvc_pkg::SINE_ROM[ridx[tvc_pkg::QTR_AW-1:0]];
            f_sine = ti[tvc_pkg::SIN_AW-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    endfunction

    function automatic logic [PW-1:0] f_pos(input logic [AW-1:0] rp,
                                            input logic [11:0] d,
                                            input logic signed [15:0] s);
        logic signed [28:0] prod;
        logic signed [28:0] off;
        begin
            prod = $signed({1'b0, d}) * s;
            off = prod >>> (15 - FB);
            f_pos = {rp, {FB{1'b0}}} + PW'(off);
        end
    endfunction

    function automatic logic signed [WW-1:0] f_interp(input logic signed [SB-1:0] x0,
                                                      input logic signed [SB-1:0] x1,
                                                      input logic [FB-1:0] fr);
        logic signed [SB:0] diff;
        logic signed [WW-1:0] slope;
        begin
            diff = $signed({x1[SB-1], x1}) - $signed({x0[SB-1], x0});
            slope = $signed({1'b0, fr}) * diff;
            f_interp = ($signed(WW'(x0)) <<< FB) + slope;
        end
    endfunction

    // delay RAM port control
    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [SB-1:0] wdata, rdata;
    logic [11:0] maxd;

    assign maxd = (r_d1 > r_d2) ? r_d1 : r_d2;

    always_comb begin
        we = 1'b0;
        waddr = r_clr;
        wdata = '0;
        if (r_state == S_CLEAR) begin
            we = 1'b1;
        end else if (r_state == S_WRITE) begin
            we = 1'b1;
            waddr = r_rp + AW'(1) + AW'(maxd);
            wdata = r_dry;
        end
    end

    always_comb begin
        case (r_rd[1:0])
            2'd0:    raddr = r_pos1[PW-1 -: AW];
            2'd1:    raddr = r_pos1[PW-1 -: AW] + AW'(1);
            2'd2:    raddr = r_pos2[PW-1 -: AW];
            default: raddr = r_pos2[PW-1 -: AW] + AW'(1);
        endcase
    end

    tvc_ram #(.WIDTH(SB), .DEPTH(tvc_pkg::DELAY_DEPTH)) u_dly (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // mix
    logic signed [17:0] dg;
    logic signed [AccW-1:0] acc;
    logic signed [AccW-1:0] yq;
    logic signed [SB-1:0] ysat;
    logic load_out;

    assign dg = 18'sd32768 - $signed({2'b0, r_g1}) - $signed({2'b0, r_g2});
    assign acc = (r_p0 <<< FB) + r_p1 + r_p2 + (AccW'(1) <<< (14 + FB));
    assign yq = acc >>> (15 + FB);

    always_comb begin
        if (yq > AccW'((1 << (SB - 1)) - 1)) begin
            ysat = {1'b0, {(SB-1){1'b1}}};
        end else if (yq < -AccW'(1 << (SB - 1))) begin
            ysat = {1'b1, {(SB-1){1'b0}}};
        end else begin
            ysat = yq[SB-1:0];
        end
    end

    assign load_out = (r_state == S_SUM) && (!r_ovalid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == {AW{1'b1}}) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_WRITE;
            S_WRITE: n_state = S_READ;
            S_READ:  if (r_rd == 3'd4) n_state = S_VOICE;
            S_VOICE: n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   if (load_out) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_rp     <= '0;
            r_ph1    <= '0;
            r_ph2    <= '0;
            r_rd     <= '0;
            r_ovalid <= 1'b0;
            r_g1     <= 16'd11469;
            r_g2     <= 16'd11469;
            r_d1     <= 12'd397;
            r_d2     <= 12'd397;
            r_step1  <= 32'd389566;
            r_step2  <= 32'd292175;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tvc_pkg::CFG_G1:    r_g1    <= i_cfg_data[15:0];
                    tvc_pkg::CFG_G2:    r_g2    <= i_cfg_data[15:0];
                    tvc_pkg::CFG_D1:    r_d1    <= i_cfg_data[11:0];
                    tvc_pkg::CFG_D2:    r_d2    <= i_cfg_data[11:0];
                    tvc_pkg::CFG_STEP1: r_step1 <= i_cfg_data;
                    tvc_pkg::CFG_STEP2: r_step2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_IDLE && i_in_valid) begin
                r_ph1 <= r_ph1 + r_step1;
                r_ph2 <= r_ph2 + r_step2;
            end
            if (r_state == S_WRITE) begin
                r_rp <= r_rp + AW'(1);
            end
            if (r_state == S_READ) begin
                r_rd <= (r_rd == 3'd4) ? 3'd0 : r_rd + 3'd1;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_dry  <= i_sample_in;
            r_sin1 <= f_sine(r_ph1);
            r_sin2 <= f_sine(r_ph2);
        end
        if (r_state == S_WRITE) begin
            r_pos1 <= f_pos(r_rp, r_d1, r_sin1);
            r_pos2 <= f_pos(r_rp, r_d2, r_sin2);
        end
        if (r_state == S_READ && r_rd != 3'd0) begin
            r_x[r_rd[1:0] - 2'd1] <= rdata;
        end
        if (r_state == S_VOICE) begin
            r_w1 <= f_interp(r_x[0], r_x[1], r_pos1[FB-1:0]);
            r_w2 <= f_interp(r_x[2], r_x[3], r_pos2[FB-1:0]);
        end
        if (r_state == S_MUL) begin
            r_p0 <= AccW'(dg) * AccW'(r_dry);
            r_p1 <= AccW'($signed({1'b0, r_g1})) * AccW'(r_w1);
            r_p2 <= AccW'($signed({1'b0, r_g2})) * AccW'(r_w2);
        end
        if (load_out) begin
            r_y <= ysat;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_ovalid;
    assign o_sample_out = r_y;

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_WRITE)) else $error("accept lost");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready) else $error("ready during clear");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (o_out_valid && r_state == S_IDLE)) else $error("result not shown");
    a_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_READ) |-> (r_rd == 3'd0)) else $error("read count stray");
endmodule

// File: bench/two_voice_chorus_tb.sv
// Testbench for two_voice_chorus: drives samples and register writes, predicts
// every output sample with its own chorus model and checks it. Depends on tvc_pkg.
`timescale 1ns / 1ps

class chorus_scoreboard;
    localparam int DD = tvc_pkg::DELAY_DEPTH;
    localparam int ST = tvc_pkg::SINE_TABLE_DEPTH;

    int                sine_lut[ST];
    logic signed [15:0] line_mem[DD];
    logic [12:0]       rd_ptr;
    logic [31:0]       ph1, ph2;
    logic [15:0]       g1, g2;
    logic [11:0]       d1, d2;
    logic [31:0]       step1, step2;
    logic signed [15:0] pending[$];
    int                errors;

    function new();
        longint unsigned p, r, x, x2, pp, s, q;
        int quad;
        for (int k = 0; k < ST; k++) begin
            p = (longint'(k) << 32) / ST;
            quad = int'((p >> 30) & 3);
            r = p & ((64'd1 << 30) - 1);
            if (quad & 1) r = (64'd1 << 30) - r;
            x = (r * 64'd1686629713) >> 30;
            x2 = (x * x) >> 30;
            pp = 64'd1 << 30;
            pp = (64'd1 << 30) - ((x2 * pp) >> 30) / 110;
            pp = (64'd1 << 30) - ((x2 * pp) >> 30) / 72;
            pp = (64'd1 << 30) - ((x2 * pp) >> 30) / 42;
            pp = (64'd1 << 30) - ((x2 * pp) >> 30) / 20;
            pp = (64'd1 << 30) - ((x2 * pp) >> 30) / 6;
            s = (x * pp) >> 30;
            q = (s + 16384) >> 15;
            if (q > 32767) q = 32767;
            sine_lut[k] = (quad & 2) ? -int'(q) : int'(q);
        end
        foreach (line_mem[i]) line_mem[i] = '0;
        rd_ptr = '0; ph1 = '0; ph2 = '0;
        g1 = 16'd11469; g2 = 16'd11469; d1 = 12'd397; d2 = 12'd397;
        step1 = 32'd389566; step2 = 32'd292175;
        errors = 0;
    endfunction

    function void write_reg(tvc_pkg::t_cfg_idx idx, logic [31:0] data);
        case (idx)
            tvc_pkg::CFG_G1:    g1 = data[15:0];
            tvc_pkg::CFG_G2:    g2 = data[15:0];
            tvc_pkg::CFG_D1:    d1 = data[11:0];
            tvc_pkg::CFG_D2:    d2 = data[11:0];
            tvc_pkg::CFG_STEP1: step1 = data;
            tvc_pkg::CFG_STEP2: step2 = data;
            default: ;
        endcase
    endfunction

    function longint voice_q8(logic [11:0] depth, logic [31:0] phase);
        longint m, prod, pos, x0, x1;
        int ti, idx, nxt, frac;
        m = longint'(DD) << 8;
        ti = int'((longint'(phase) * ST) >> 32);
        prod = longint'(depth) * sine_lut[ti];
        pos = (longint'(rd_ptr) << 8) + (prod >>> 7);
        pos = pos % m;
        if (pos < 0) pos += m;
        idx = int'(pos >> 8);
        frac = int'(pos & 255);
        nxt = (idx + 1 >= DD) ? 0 : idx + 1;
        x0 = line_mem[idx];
        x1 = line_mem[nxt];
        return x0 * 256 + frac * (x1 - x0);
    endfunction

    function void note_sample(logic signed [15:0] dry);
        longint w1, w2, acc, y;
        int unsigned maxd;
        maxd = (d1 > d2) ? d1 : d2;
        line_mem[(int'(rd_ptr) + 1 + maxd) % DD] = dry;
        w1 = voice_q8(d1, ph1);
        w2 = voice_q8(d2, ph2);
        acc = (32768 - longint'(g1) - longint'(g2)) * longint'(dry) * 256
            + longint'(g1) * w1 + longint'(g2) * w2;
        y = (acc + (longint'(1) << 22)) >>> 23;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        pending.push_back(16'(y));
        ph1 += step1;
        ph2 += step2;
        rd_ptr += 1'b1;
    endfunction

    function void check_sample(logic signed [15:0] got);
        logic signed [15:0] exp_v;
        if (pending.size() == 0) begin
            $display("%0t: unexpected sample_out %0d", $time, got);
            errors++;
            return;
        end
        exp_v = pending.pop_front();
        if (got !== exp_v) begin
            $display("%0t: sample_out expected %0d actual %0d", $time, exp_v, got);
            errors++;
        end
    endfunction
endclass

module two_voice_chorus_tb;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic signed [15:0] sample_in = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_ready, out_valid, cfg_ready;
    logic signed [15:0] sample_out;
    longint             cycles = 0;
    int                 stall_mode = 0;
    chorus_scoreboard   sb;

    two_voice_chorus i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_sample_in(sample_in),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_sample_out(sample_out),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("two_voice_chorus verification failed");
            $finish;
        end
    end

    // receiver: checks at the edge, then picks the next stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) sb.check_sample(sample_out);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= cycles[3];
        endcase
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    end

    // valid stays high between back-to-back requests; callers drop it before gaps
    task automatic send_sample(logic signed [15:0] v);
        cfg_valid <= 1'b0;
        in_valid <= 1'b1;
        sample_in <= v;
        do @(posedge i_clk); while (!in_ready);
        sb.note_sample(v);
    endtask

    task automatic write_reg(tvc_pkg::t_cfg_idx idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_burst(int n);
        int left;
        left = n;
        while (left > 0) begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && left > 0; k++, left--) begin
                case ($urandom_range(0, 5))
                    0: send_sample(16'sh7fff);
                    1: send_sample(16'sh8000);
                    2: send_sample(16'($urandom_range(0, 255)) - 16'sd128);
                    default: send_sample(16'($urandom));
                endcase
            end
            if ($urandom_range(0, 2) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        drain();
        // gains of one each, full depth
        write_reg(tvc_pkg::CFG_G1, 32'd32768);
        write_reg(tvc_pkg::CFG_G2, 32'd32768);
        write_reg(tvc_pkg::CFG_D1, 32'd4095);
        write_reg(tvc_pkg::CFG_D2, 32'd0);
        write_reg(tvc_pkg::CFG_STEP1, 32'hffff_ffff);
        write_reg(tvc_pkg::CFG_STEP2, 32'h4000_0000);
        repeat (6) send_sample(16'sh7fff);
        repeat (6) send_sample(16'sh8000);
        drain();
        write_reg(tvc_pkg::CFG_G1, 32'd0);
        write_reg(tvc_pkg::CFG_G2, 32'd0);
        write_reg(tvc_pkg::CFG_D1, 32'd4000);
        write_reg(tvc_pkg::CFG_D2, 32'd4000);
        write_reg(tvc_pkg::CFG_STEP1, 32'd0);
        write_reg(tvc_pkg::CFG_STEP2, 32'd12345);
        repeat (8) send_sample(16'($urandom));
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(tvc_pkg::CFG_G1, $urandom_range(0, 32768));
            write_reg(tvc_pkg::CFG_G2, ph == 5 ? 32'hffff_ffff : $urandom_range(0, 32768));
            write_reg(tvc_pkg::CFG_D1, ph == 2 ? 32'hfff : $urandom_range(0, 4000));
            write_reg(tvc_pkg::CFG_D2, $urandom_range(0, 4095));
            write_reg(tvc_pkg::CFG_STEP1, ph == 3 ? 32'hffff_ffff : $urandom);
            write_reg(tvc_pkg::CFG_STEP2, ph < 3 ? $urandom_range(0, 5000000) : $urandom);
            random_burst(255);
            drain();
        end
        if (sb.errors == 0) begin
            $display("two_voice_chorus verification clean");
        end else begin
            $display("two_voice_chorus verification failed");
        end
        $finish;
    end
endmodule
